@@ src/smm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_pkg
// Types, codes and constants shared by the scaled matrix multiply block.
// ----------------------------------------------------------------------------
package smm_pkg;

  localparam int IDX_W    = 3;
  localparam int DIM_W    = 4;
  localparam int ELEM_W   = 16;
  localparam int SCALE_W  = 16;
  localparam int OUT_W    = 48;
  localparam int ACC_W    = 64;
  localparam int SOP_W    = 33;
  localparam int SPROD_W  = SOP_W + SCALE_W;
  localparam int FULL_W   = 81;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] KIND_LOAD_A  = 2'd0;
  localparam logic [1:0] KIND_LOAD_B  = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 2'd3;

  localparam logic signed [ACC_W:0] ACC_POS = 65'sh0_4000_0000_0000_0000;
  localparam logic signed [ACC_W:0] ACC_NEG = -ACC_POS;

  localparam logic [OUT_W-1:0] OUT_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [OUT_W-1:0] OUT_MIN = 48'h8000_0000_0000;

  typedef struct packed {
    logic [1:0]              kind;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [ELEM_W-1:0] element;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [OUT_W-1:0] product_sum;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             rd;
    logic             acc_clr;
    logic             scl_lo;
    logic             scl_hi;
    logic             emit;
    logic             last;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } sts_t;

  function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] v,
                                              input logic [DIM_W-1:0] lim);
    return (v > lim) ? lim : v;
  endfunction

endpackage

@@ src/smm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module smm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/smm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_ctrl
// Sequencer: takes load and compute items, walks the result elements and
// steps the datapath through accumulate, scale and emit.
// ----------------------------------------------------------------------------
module smm_ctrl #(
  parameter int MAX_DIM = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  smm_pkg::in_item_t          in_data,
  input  logic [smm_pkg::DIM_W-1:0]  rows_a,
  input  logic [smm_pkg::DIM_W-1:0]  inner_dim,
  input  logic [smm_pkg::DIM_W-1:0]  cols_b,
  output smm_pkg::cmd_t              cmd,
  input  smm_pkg::sts_t              sts
);
  import smm_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MAC    = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_SCL_LO = 3'd3;
  localparam logic [2:0] ST_SCL_HI = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  localparam logic [DIM_W-1:0] DIM_LIM = DIM_W'(MAX_DIM);

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [DIM_W-1:0] m_r, m_nxt, n_r, n_nxt, r_r, r_nxt;
  logic [DIM_W-1:0] m_new, n_new, r_new;
  logic             in_acc;
  logic             last_elem;
  logic             last_k;

  assign m_new = dim_of(rows_a, DIM_LIM);
  assign n_new = dim_of(inner_dim, DIM_LIM);
  assign r_new = dim_of(cols_b, DIM_LIM);

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && (state_r == ST_IDLE);
  assign last_k    = ({1'b0, k_r} == r_r - 4'd1);
  assign last_elem = ({1'b0, i_r} == m_r - 4'd1) && last_k;

  always_comb begin
    state_nxt   = state_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    m_nxt       = m_r;
    n_nxt       = n_r;
    r_nxt       = r_r;
    cmd         = '0;
    cmd.i       = i_r;
    cmd.j       = j_r;
    cmd.k       = k_r;
    cmd.last    = last_elem;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data.kind)
            KIND_LOAD_A: begin
              cmd.wr_a = 1'b1;
            end
            KIND_LOAD_B: begin
              cmd.wr_b = 1'b1;
            end
            KIND_COMPUTE: begin
              m_nxt = m_new;
              n_nxt = n_new;
              r_nxt = r_new;
              i_nxt = '0;
              j_nxt = '0;
              k_nxt = '0;
              if (m_new != '0 && r_new != '0) begin
                cmd.acc_clr = 1'b1;
                state_nxt   = (n_new == '0) ? ST_DRAIN : ST_MAC;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        cmd.rd = 1'b1;
        if ({1'b0, j_r} == n_r - 4'd1) begin
          j_nxt     = '0;
          state_nxt = ST_DRAIN;
        end else begin
          j_nxt = j_r + 3'd1;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_SCL_LO;
        end
      end
      ST_SCL_LO: begin
        cmd.scl_lo = 1'b1;
        state_nxt  = ST_SCL_HI;
      end
      ST_SCL_HI: begin
        cmd.scl_hi = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (last_elem) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.acc_clr = 1'b1;
            if (last_k) begin
              k_nxt = '0;
              i_nxt = i_r + 3'd1;
            end else begin
              k_nxt = k_r + 3'd1;
            end
            state_nxt = (n_r == '0) ? ST_DRAIN : ST_MAC;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      m_r     <= '0;
      n_r     <= '0;
      r_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      m_r     <= m_nxt;
      n_r     <= n_nxt;
      r_r     <= r_nxt;
    end
  end

  a_scale_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scl_lo |=> cmd.scl_hi)
    else $error("scale low half not followed by high half");

  a_scale_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scl_lo |-> !sts.pipe_busy)
    else $error("scaling started with products in flight");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> ({1'b0, i_r} < m_r) && ({1'b0, k_r} < r_r))
    else $error("result index outside the matrix");

endmodule

@@ src/smm_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_dp
// Datapath: A and B stores, multiply-accumulate pipe, scale multiplier with
// rounding and saturation, and the result register.
// ----------------------------------------------------------------------------
module smm_dp #(
  parameter int MAX_DIM   = 8,
  parameter int ELEM_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  smm_pkg::in_item_t                  in_data,
  input  logic signed [smm_pkg::SCALE_W-1:0] scale,
  input  smm_pkg::cmd_t                      cmd,
  output smm_pkg::sts_t                      sts,
  output logic                               out_valid,
  input  logic                               out_stall,
  output smm_pkg::out_item_t                 out_data
);
  import smm_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LOAD_W = (ELEM_BITS < ELEM_W) ? ELEM_BITS : ELEM_W;
  localparam int PROD_W = 2 * ELEM_BITS;

  logic [ADDR_W-1:0]          waddr, a_raddr, b_raddr;
  logic [ELEM_BITS-1:0]       wr_elem;
  logic                       in_range;
  logic [ELEM_BITS-1:0]       a_rdata, b_rdata;

  logic                       rd_vld_r;
  logic                       mul_vld_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [ACC_W:0]      acc_sum;

  logic signed [SOP_W-1:0]    sop;
  logic signed [SPROD_W-1:0]  sprod;
  logic signed [SPROD_W-1:0]  plo_r, phi_r;
  logic signed [FULL_W-1:0]   full_w;
  logic [FULL_W-9:0]          shf;
  logic                       sat_ok;
  logic [OUT_W-1:0]           res;

  logic                       out_valid_r;
  out_item_t                  out_data_r;

  assign in_range = (32'(in_data.row) < MAX_DIM) && (32'(in_data.col) < MAX_DIM);
  assign waddr    = ADDR_W'(32'(in_data.row) * MAX_DIM + 32'(in_data.col));
  assign wr_elem  = ELEM_BITS'(in_data.element[LOAD_W-1:0]);
  assign a_raddr  = ADDR_W'(32'(cmd.i) * MAX_DIM + 32'(cmd.j));
  assign b_raddr  = ADDR_W'(32'(cmd.j) * MAX_DIM + 32'(cmd.k));

  smm_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (DEPTH)
  ) u_a_store (
    .clk   (clk),
    .we    (cmd.wr_a && in_range),
    .waddr (waddr),
    .wdata (wr_elem),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  smm_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (DEPTH)
  ) u_b_store (
    .clk   (clk),
    .we    (cmd.wr_b && in_range),
    .waddr (waddr),
    .wdata (wr_elem),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // saturating accumulate at +-2^62
  assign acc_sum = (ACC_W+1)'(acc_r) + (ACC_W+1)'(prod_r);

  always_comb begin
    if (acc_sum > ACC_POS) begin
      acc_nxt = ACC_W'(ACC_POS);
    end else if (acc_sum < ACC_NEG) begin
      acc_nxt = ACC_W'(ACC_NEG);
    end else begin
      acc_nxt = ACC_W'(acc_sum);
    end
  end

  // scale in two 33 x 16 halves
  assign sop    = cmd.scl_lo ? $signed({1'b0, acc_r[31:0]})
                             : $signed({acc_r[ACC_W-1], acc_r[ACC_W-1:32]});
  assign sprod  = sop * scale;
  assign full_w = $signed({phi_r, 32'd0}) + FULL_W'(plo_r);
  assign shf    = full_w[FULL_W-1:8];
  assign sat_ok = (&shf[FULL_W-9:OUT_W-1]) || !(|shf[FULL_W-9:OUT_W-1]);
  assign res    = sat_ok ? shf[OUT_W-1:0] : (shf[FULL_W-9] ? OUT_MIN : OUT_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r    <= 1'b0;
      mul_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r  <= cmd.rd;
      mul_vld_r <= rd_vld_r;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      prod_r <= $signed(a_rdata) * $signed(b_rdata);
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (mul_vld_r) begin
      acc_r <= acc_nxt;
    end
    if (cmd.scl_lo) begin
      plo_r <= sprod;
    end
    if (cmd.scl_hi) begin
      phi_r <= sprod;
    end
    if (cmd.emit) begin
      out_data_r.out_row     <= cmd.i;
      out_data_r.out_col     <= cmd.k;
      out_data_r.product_sum <= res;
      out_data_r.last        <= cmd.last;
    end
  end

  assign sts.pipe_busy = rd_vld_r || mul_vld_r;
  assign sts.out_free  = !out_valid_r || !out_stall;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  a_clr_vs_acc: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.acc_clr && mul_vld_r))
    else $error("accumulator cleared while a product lands");

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while stalled");

  a_rd_vs_load: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.rd && (cmd.wr_a || cmd.wr_b)))
    else $error("store load during a multiply pass");

endmodule

@@ src/scaled_matrix_multiply.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_matrix_multiply
// C = scale * A * B over signed Q8.8 elements, results in Q32.16.
// ----------------------------------------------------------------------------
// A load item writes one element of A or B, and loads can arrive back to
// back. For a compute item one multiply-accumulate unit reads one A and one
// B element per cycle from the two stores, the last products pass through
// the store read and product registers into the accumulator, then each
// result element takes a scale multiply in low and high halves and goes
// into the output register, which holds it while out_stall is high. With
// inner_dim at zero the multiply-accumulate pass is skipped. New items are
// taken once the last result of a run sits in the output register. Store
// entries come up undefined after reset and must be loaded before use.
module scaled_matrix_multiply #(
  parameter int MAX_DIM   = 8,
  parameter int ELEM_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  smm_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output smm_pkg::out_item_t                   out_data,
  input  logic                                 cfg_we,
  input  logic [smm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [smm_pkg::SCALE_W-1:0]          cfg_data
);
  import smm_pkg::*;

  logic [DIM_W-1:0]          rows_a_r, inner_dim_r, cols_b_r;
  logic signed [SCALE_W-1:0] scale_r;
  cmd_t                      cmd;
  sts_t                      sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= 4'd8;
      inner_dim_r <= 4'd8;
      cols_b_r    <= 4'd8;
      scale_r     <= 16'sd256;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS_A:    rows_a_r    <= cfg_data[DIM_W-1:0];
        CFG_INNER_DIM: inner_dim_r <= cfg_data[DIM_W-1:0];
        CFG_COLS_B:    cols_b_r    <= cfg_data[DIM_W-1:0];
        CFG_SCALE:     scale_r     <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  smm_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .rows_a    (rows_a_r),
    .inner_dim (inner_dim_r),
    .cols_b    (cols_b_r),
    .cmd       (cmd),
    .sts       (sts)
  );

  smm_dp #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_BITS (ELEM_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .scale     (scale_r),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ verif/tb_scaled_matrix_multiply.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scaled_matrix_multiply
// Self-checking bench for the scaled matrix multiply block. Loads of A and B
// and compute items are queued to a driver; every accepted item also updates
// a local copy of both stores, and each compute item lays down the C
// elements it should produce. A monitor checks each result against the
// oldest of those. Dimensions and scale change only between runs, once the
// block has gone quiet. Both sides idle at random, and one run holds the
// output off long enough for the input side to back up.
// ----------------------------------------------------------------------------
module tb_scaled_matrix_multiply;
  import smm_pkg::*;

  localparam int DIM_MAX = 8;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam longint PS_MAX = (longint'(1) <<< 47) - 1;
  localparam longint PS_MIN = -(longint'(1) <<< 47);
  localparam int QUIET_SHORT = 4;
  localparam int QUIET_LONG = 900;
  localparam int LONG_HOLD = 1500;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SCALE_W-1:0] cfg_data = '0;

  scaled_matrix_multiply uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // local copy of the block state
  logic signed [ELEM_W-1:0] a_mem [DIM_MAX*DIM_MAX];
  logic signed [ELEM_W-1:0] b_mem [DIM_MAX*DIM_MAX];
  logic [DIM_W-1:0] cfg_rows = 4'd8;
  logic [DIM_W-1:0] cfg_inner = 4'd8;
  logic [DIM_W-1:0] cfg_cols = 4'd8;
  logic signed [SCALE_W-1:0] cfg_scale = 16'sd256;

  in_item_t matrix_ops_q[$];
  out_item_t c_elems_exp[$];
  bit a_known [DIM_MAX*DIM_MAX];
  bit b_known [DIM_MAX*DIM_MAX];
  int ops_queued = 0;
  int ops_taken = 0;
  int useful_ops = 0;
  int mismatches = 0;
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  bit tx_gappy = 1'b0;
  bit rx_gappy = 1'b0;
  int tx_gap = 0;
  int rx_wait = 0;
  int hold_cnt = 0;
  int hold_asks = 0;
  int hold_seen = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int clip_dim(input logic [DIM_W-1:0] d);
    return (d > DIM_MAX) ? DIM_MAX : int'(d);
  endfunction

  function automatic void apply_matrix_op(input in_item_t op);
    int m, n, r;
    longint acc, scaled;
    out_item_t c;
    case (op.kind)
      KIND_LOAD_A: a_mem[{op.row, op.col}] = op.element;
      KIND_LOAD_B: b_mem[{op.row, op.col}] = op.element;
      KIND_COMPUTE: begin
        m = clip_dim(cfg_rows);
        n = clip_dim(cfg_inner);
        r = clip_dim(cfg_cols);
        for (int i = 0; i < m; i++) begin
          for (int k = 0; k < r; k++) begin
            acc = 0;
            for (int j = 0; j < n; j++)
              acc += longint'(a_mem[i*DIM_MAX+j]) * longint'(b_mem[j*DIM_MAX+k]);
            scaled = (acc * longint'(cfg_scale)) >>> 8;
            if (scaled > PS_MAX) scaled = PS_MAX;
            else if (scaled < PS_MIN) scaled = PS_MIN;
            c.out_row = IDX_W'(i);
            c.out_col = IDX_W'(k);
            c.product_sum = scaled[OUT_W-1:0];
            c.last = (i == m - 1) && (k == r - 1);
            c_elems_exp.push_back(c);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // input side: acceptance and prediction
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      apply_matrix_op(in_data);
      ops_taken++;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else if (!in_valid || in_taken) begin
      if (tx_gap != 0) begin
        in_valid <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (matrix_ops_q.size() != 0) begin
        in_data <= matrix_ops_q.pop_front();
        in_valid <= 1'b1;
        tx_gap <= tx_gappy ? $urandom_range(0, 10) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side: stall generation
  always @(negedge clk) begin : rx_drive
    int w;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait <= 0;
      hold_cnt <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_cnt <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (out_taken) begin
      w = rx_gappy ? $urandom_range(0, 10) : 0;
      rx_wait <= w;
      out_stall <= (w != 0);
    end else if (rx_wait > 1) begin
      rx_wait <= rx_wait - 1;
      out_stall <= 1'b1;
    end else begin
      rx_wait <= 0;
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : c_check
    out_item_t want;
    out_taken <= rst_n && out_valid && !out_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (c_elems_exp.size() == 0) begin
        $error("unexpected C element row %0d col %0d value %0d",
               out_data.out_row, out_data.out_col, out_data.product_sum);
        mismatches++;
      end else begin
        want = c_elems_exp.pop_front();
        if (out_data.out_row !== want.out_row) begin
          $error("out_row: expected %0d, got %0d", want.out_row, out_data.out_row);
          mismatches++;
        end
        if (out_data.out_col !== want.out_col) begin
          $error("out_col: expected %0d, got %0d", want.out_col, out_data.out_col);
          mismatches++;
        end
        if (out_data.product_sum !== want.product_sum) begin
          $error("product_sum: expected %0d, got %0d",
                 want.product_sum, out_data.product_sum);
          mismatches++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_data.last);
          mismatches++;
        end
      end
    end
  end

  function automatic in_item_t build_op(input logic [1:0] kind, input int row, input int col,
                                        input logic [ELEM_W-1:0] elem);
    in_item_t op;
    op.kind = kind;
    op.row = IDX_W'(row);
    op.col = IDX_W'(col);
    op.element = elem;
    return op;
  endfunction

  function automatic logic [ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [SCALE_W-1:0] rand_scale();
    case ($urandom_range(0, 5))
      0: return 16'h0100;
      1: return 16'h8000;
      2: return 16'h7FFF;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] rand_dim();
    if ($urandom_range(0, 9) == 0) return DIM_W'($urandom_range(0, 15));
    return DIM_W'($urandom_range(1, 3));
  endfunction

  function automatic in_item_t compute_op();
    return build_op(KIND_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), 16'($urandom));
  endfunction

  function automatic in_item_t noise_op();
    logic [1:0] kind;
    case ($urandom_range(0, 2))
      0: kind = KIND_LOAD_A;
      1: kind = KIND_LOAD_B;
      default: kind = KIND_UNUSED;
    endcase
    return build_op(kind, $urandom_range(0, 7), $urandom_range(0, 7), rand_elem());
  endfunction

  task automatic queue_op(input in_item_t op);
    matrix_ops_q.push_back(op);
    ops_queued++;
    if (op.kind == KIND_LOAD_A) a_known[{op.row, op.col}] = 1'b1;
    else if (op.kind == KIND_LOAD_B) b_known[{op.row, op.col}] = 1'b1;
    if (op.kind != KIND_UNUSED) useful_ops++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_ROWS_A: cfg_rows = data[DIM_W-1:0];
      CFG_INNER_DIM: cfg_inner = data[DIM_W-1:0];
      CFG_COLS_B: cfg_cols = data[DIM_W-1:0];
      CFG_SCALE: cfg_scale = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_dims(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] inner,
                          input logic [DIM_W-1:0] cols, input logic [SCALE_W-1:0] scl);
    write_reg(CFG_ROWS_A, {12'($urandom), rows});
    write_reg(CFG_INNER_DIM, {12'($urandom), inner});
    write_reg(CFG_COLS_B, {12'($urandom), cols});
    write_reg(CFG_SCALE, scl);
  endtask

  task automatic drain(input int quiet);
    while (ops_taken != ops_queued || c_elems_exp.size() != 0) @(negedge clk);
    repeat (quiet) @(negedge clk);
  endtask

  // one run: set up, load what the product reads, compute
  task automatic run_case(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] inner,
                          input logic [DIM_W-1:0] cols, input logic [SCALE_W-1:0] scl,
                          input bit hold);
    int m, n, r, q;
    in_item_t loads[$];
    in_item_t tmp;
    m = clip_dim(rows);
    n = clip_dim(inner);
    r = clip_dim(cols);
    set_dims(rows, inner, cols, scl);
    tx_gappy = $urandom_range(0, 2) != 0;
    rx_gappy = $urandom_range(0, 2) != 0;
    for (int i = 0; i < m; i++)
      for (int j = 0; j < n; j++)
        if (!a_known[i*DIM_MAX+j] || $urandom_range(0, 1))
          loads.push_back(build_op(KIND_LOAD_A, i, j, rand_elem()));
    for (int j = 0; j < n; j++)
      for (int k = 0; k < r; k++)
        if (!b_known[j*DIM_MAX+k] || $urandom_range(0, 1))
          loads.push_back(build_op(KIND_LOAD_B, j, k, rand_elem()));
    repeat ($urandom_range(0, 3)) loads.push_back(noise_op());
    for (int p = loads.size() - 1; p > 0; p--) begin
      q = $urandom_range(0, p);
      tmp = loads[p];
      loads[p] = loads[q];
      loads[q] = tmp;
    end
    if (hold) hold_asks++;
    foreach (loads[p]) queue_op(loads[p]);
    queue_op(compute_op());
    if (hold || $urandom_range(0, 3) == 0) queue_op(compute_op());
    if (hold) repeat (8) queue_op(noise_op());
    drain((m == 0 || r == 0) ? QUIET_LONG : QUIET_SHORT);
  endtask

  initial begin : stimulus
    int case_no;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // most negative operands, both scale extremes, zero scale
    set_dims(4'd1, 4'd1, 4'd1, 16'h8000);
    queue_op(build_op(KIND_LOAD_A, 0, 0, 16'h8000));
    queue_op(build_op(KIND_LOAD_B, 0, 0, 16'h8000));
    queue_op(compute_op());
    queue_op(build_op(KIND_UNUSED, 7, 7, 16'($urandom)));
    drain(QUIET_SHORT);
    set_dims(4'd1, 4'd1, 4'd1, 16'h7FFF);
    queue_op(build_op(KIND_LOAD_A, 0, 0, 16'h7FFF));
    queue_op(compute_op());
    drain(QUIET_SHORT);
    set_dims(4'd1, 4'd1, 4'd1, 16'h0000);
    queue_op(compute_op());
    drain(QUIET_SHORT);

    // oversized dimensions clip, empty inner sum gives zeros
    set_dims(4'd15, 4'd0, 4'd9, 16'h0100);
    queue_op(compute_op());
    drain(QUIET_SHORT);

    // no rows or no columns: nothing comes out
    set_dims(4'd0, 4'd8, 4'd8, 16'h0100);
    queue_op(compute_op());
    drain(QUIET_LONG);
    set_dims(4'd2, 4'd2, 4'd0, 16'hFFFF);
    queue_op(compute_op());
    drain(QUIET_LONG);

    // negative scale, rounding towards minus infinity
    set_dims(4'd1, 4'd2, 4'd2, 16'hFFFF);
    queue_op(build_op(KIND_LOAD_A, 0, 1, 16'hFFFF));
    queue_op(build_op(KIND_LOAD_B, 1, 0, 16'h7FFF));
    queue_op(build_op(KIND_LOAD_B, 0, 1, 16'h8000));
    queue_op(build_op(KIND_LOAD_B, 1, 1, 16'h0001));
    queue_op(compute_op());
    drain(QUIET_SHORT);

    case_no = 0;
    while (useful_ops < 270) begin
      if (case_no == 2) run_case(4'd3, 4'd3, 4'd3, rand_scale(), 1'b1);
      else if (case_no == 5) run_case(4'd8, 4'd8, 4'd8, rand_scale(), 1'b0);
      else run_case(rand_dim(), rand_dim(), rand_dim(), rand_scale(), 1'b0);
      case_no++;
    end
    run_case(4'd15, 4'd12, 4'd9, 16'h8000, 1'b0);

    drain(QUIET_LONG);
    if (mismatches == 0) begin
      $display("PASS scaled_matrix_multiply");
    end else begin
      $display("FAIL scaled_matrix_multiply");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("FAIL scaled_matrix_multiply");
    $finish;
  end

endmodule
